@@ design/ack_pkg.sv @@
// Package for the Ackermann steering command block.
// Holds the CORDIC arctangent table, payload widths and register indexes.
`default_nettype none
package ack_pkg;
    localparam int TABLE_LEN = 24;
    localparam int CW = 58;  // CORDIC x/y width
    localparam int ZW = 32;  // angle accumulator width

    localparam logic [2:0] REG_WHEELBASE = 3'd0;
    localparam logic [2:0] REG_MAX_STEER = 3'd1;
    localparam logic [2:0] REG_MAX_LIN   = 3'd2;
    localparam logic [2:0] REG_MAX_TURN  = 3'd3;
    localparam logic [2:0] REG_MIN_SPEED = 3'd4;

    typedef logic [15:0] cfg_data_t;

    function automatic logic signed [ZW-1:0] atan_entry(input logic [4:0] i);
        logic signed [ZW-1:0] v;
        case (i)
            5'd0: v = 32'sd843314857;
            5'd1: v = 32'sd497837829;
            5'd2: v = 32'sd263043837;
            5'd3: v = 32'sd133525159;
            5'd4: v = 32'sd67021687;
            5'd5: v = 32'sd33543516;
            5'd6: v = 32'sd16775851;
            5'd7: v = 32'sd8388437;
            5'd8: v = 32'sd4194283;
            5'd9: v = 32'sd2097149;
            5'd10: v = 32'sd1048576;
            5'd11: v = 32'sd524288;
            5'd12: v = 32'sd262144;
            5'd13: v = 32'sd131072;
            5'd14: v = 32'sd65536;
            5'd15: v = 32'sd32768;
            5'd16: v = 32'sd16384;
            5'd17: v = 32'sd8192;
            5'd18: v = 32'sd4096;
            5'd19: v = 32'sd2048;
            5'd20: v = 32'sd1024;
            5'd21: v = 32'sd512;
            5'd22: v = 32'sd256;
            5'd23: v = 32'sd128;
            default: v = '0;
        endcase
        return v;
    endfunction
endpackage
`default_nettype wire

@@ design/ack_cordic.sv @@
// Pipelined CORDIC vectoring unit, one stage per iteration, with sideband.
// Depends on ack_pkg.
`default_nettype none
module ack_cordic #(
    parameter int STAGES = 16,
    parameter int SW = 30
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          en,
    input  wire logic                          in_valid,
    input  wire logic signed [ack_pkg::CW-1:0] in_x,
    input  wire logic signed [ack_pkg::CW-1:0] in_y,
    input  wire logic [SW-1:0]                 in_side,
    output logic                               out_valid,
    output logic signed [ack_pkg::ZW-1:0]      out_z,
    output logic [SW-1:0]                      out_side
);
    import ack_pkg::*;

    logic                 v_reg [STAGES+1];
    logic signed [CW-1:0] x_reg [STAGES+1];
    logic signed [CW-1:0] y_reg [STAGES+1];
    logic signed [ZW-1:0] z_reg [STAGES+1];
    logic [SW-1:0]        s_reg [STAGES+1];

    always_comb
    begin
        v_reg[0] = in_valid;
        x_reg[0] = in_x;
        y_reg[0] = in_y;
        z_reg[0] = '0;
        s_reg[0] = in_side;
    end

    for (genvar i = 0; i < STAGES; i++) begin : g_stage
        logic signed [CW-1:0] xs, ys;
        logic signed [ZW-1:0] a;
        assign xs = x_reg[i] >>> i;
        assign ys = y_reg[i] >>> i;
        assign a = (i < TABLE_LEN) ? atan_entry(5'(i)) : '0;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[i+1] <= 1'b0;
            else if (en)
                v_reg[i+1] <= v_reg[i];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                s_reg[i+1] <= s_reg[i];
                if (i >= TABLE_LEN)
                begin
                    x_reg[i+1] <= x_reg[i];
                    y_reg[i+1] <= y_reg[i];
                    z_reg[i+1] <= z_reg[i];
                end
                else if (y_reg[i] > 0)
                begin
                    x_reg[i+1] <= x_reg[i] + ys;
                    y_reg[i+1] <= y_reg[i] - xs;
                    z_reg[i+1] <= z_reg[i] + a;
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] - ys;
                    y_reg[i+1] <= y_reg[i] + xs;
                    z_reg[i+1] <= z_reg[i] - a;
                end
            end
        end
    end

    assign out_valid = v_reg[STAGES];
    assign out_z     = z_reg[STAGES];
    assign out_side  = s_reg[STAGES];
endmodule
`default_nettype wire

@@ design/ackermann_steering_command.sv @@
// Ackermann steering command: clamps a velocity command and computes steering angle.
// One transfer per cycle while m_tready does not stall the pipeline.
// Pipeline is clamp, multiply, CORDIC_STAGES CORDIC stages, scale, output register.
// Stalls freeze the whole pipeline; output register holds until taken.
// rst_n clears valid bits and loads register defaults asynchronously.
`default_nettype none
module ackermann_steering_command #(
    parameter int CORDIC_STAGES = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire ack_pkg::cfg_data_t cfg_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // req_speed[15:0], turn_rate[31:16]
    input  wire logic        s_tuser,   // brake
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata    // drive_speed[15:0], steer_angle[27:16], zero
);
    import ack_pkg::*;

    localparam int SW = 16 + 1 + 1 + 11;  // speed, zero flag, zero-y flag, steer limit

    logic [15:0] wheelbase_reg;
    logic [10:0] max_steer_reg;
    logic [14:0] max_lin_reg, max_turn_reg, min_speed_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wheelbase_reg <= 16'd1000;
            max_steer_reg <= 11'd500;
            max_lin_reg   <= 15'd1000;
            max_turn_reg  <= 15'd1000;
            min_speed_reg <= 15'd10;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_WHEELBASE: wheelbase_reg <= cfg_data;
                REG_MAX_STEER: max_steer_reg <= cfg_data[10:0];
                REG_MAX_LIN:   max_lin_reg   <= cfg_data[14:0];
                REG_MAX_TURN:  max_turn_reg  <= cfg_data[14:0];
                REG_MIN_SPEED: min_speed_reg <= cfg_data[14:0];
                default: ;
            endcase
        end
    end

    logic en;
    logic out_valid_reg;
    assign en = !out_valid_reg || m_tready;
    assign s_tready = en;

    // stage 1: clamp
    logic s1_v_reg;
    logic signed [15:0] s1_speed_reg, s1_ang_reg;
    logic s1_zero_reg;
    logic signed [15:0] lin, rate, spd, ang;
    logic signed [16:0] lim_l, lim_t;
    logic [15:0] mag;
    always_comb
    begin
        lin = s_tdata[15:0];
        rate = s_tdata[31:16];
        lim_l = {2'b0, max_lin_reg};
        lim_t = {2'b0, max_turn_reg};
        if (s_tuser) spd = '0;
        else if (17'(lin) > lim_l) spd = {1'b0, max_lin_reg};
        else if (17'(lin) < -lim_l) spd = -{1'b0, max_lin_reg};
        else spd = lin;
        if (17'(rate) > lim_t) ang = {1'b0, max_turn_reg};
        else if (17'(rate) < -lim_t) ang = -{1'b0, max_turn_reg};
        else ang = rate;
        mag = spd[15] ? 16'(-spd) : 16'(spd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) s1_v_reg <= 1'b0;
        else if (en) s1_v_reg <= s_tvalid;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_zero_reg  <= mag < {1'b0, min_speed_reg};
            s1_speed_reg <= spd;
            s1_ang_reg   <= spd[15] ? 16'(-ang) : ang;
        end
    end

    // stage 2: multiply
    logic s2_v_reg;
    logic signed [15:0] s2_speed_reg;
    logic s2_zero_reg;
    logic signed [32:0] s2_y_reg;
    logic [25:0] s2_x_reg;
    logic [15:0] s1_mag;
    assign s1_mag = s1_speed_reg[15] ? 16'(-s1_speed_reg) : 16'(s1_speed_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) s2_v_reg <= 1'b0;
        else if (en) s2_v_reg <= s1_v_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_speed_reg <= s1_zero_reg ? '0 : s1_speed_reg;
            s2_zero_reg  <= s1_zero_reg;
            s2_y_reg     <= $signed({1'b0, wheelbase_reg}) * 33'(s1_ang_reg);
            s2_x_reg     <= 26'(s1_mag) * 26'd1000;
        end
    end

    logic signed [CW-1:0] cx, cy;
    assign cx = {CW'(s2_x_reg)} <<< 24;
    assign cy = CW'(s2_y_reg) <<< 24;

    logic c_v;
    logic signed [ZW-1:0] c_z;
    logic [SW-1:0] c_s;
    ack_cordic #(.STAGES(CORDIC_STAGES), .SW(SW)) u_cordic (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(s2_v_reg), .in_x(cx), .in_y(cy),
        .in_side({max_steer_reg, s2_y_reg == 0, s2_zero_reg, s2_speed_reg}),
        .out_valid(c_v), .out_z(c_z), .out_side(c_s)
    );

    // stage A: magnitude * 1000
    logic a_v_reg;
    logic [SW-1:0] a_s_reg;
    logic a_neg_reg;
    logic [41:0] a_p_reg;
    logic [31:0] zmag;
    assign zmag = c_z[ZW-1] ? 32'(-c_z) : 32'(c_z);
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) a_v_reg <= 1'b0;
        else if (en) a_v_reg <= c_v;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_s_reg   <= c_s;
            a_neg_reg <= c_z[ZW-1];
            a_p_reg   <= 42'(zmag) * 42'd1000 + (42'd1 << 29);
        end
    end

    // stage B: round, clamp, sign, force zero when the zero or zero-y flag is set
    logic [11:0] r, lim, steer;
    logic [15:0] b_speed;
    always_comb
    begin
        r = a_p_reg[41:30];
        lim = {1'b0, a_s_reg[28:18]};
        if (r > lim) r = lim;
        steer = a_neg_reg ? 12'(-r) : r;
        if (a_s_reg[16] || a_s_reg[17]) steer = '0;
        b_speed = a_s_reg[15:0];
    end

    logic [15:0] o_speed_reg;
    logic [11:0] o_steer_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) out_valid_reg <= 1'b0;
        else if (en) out_valid_reg <= a_v_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            o_speed_reg <= b_speed;
            o_steer_reg <= steer;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0, o_steer_reg, o_speed_reg};
endmodule
`default_nettype wire
